// ----- hdl/rita_pkg.sv -----
// Shared types, widths and constants of the radix integer-to-ASCII converter.
// No dependencies; every other file of the block imports this package.
package rita_pkg;

    localparam int IN_VALUE_W    = 64;
    localparam int BASE_W        = 6;
    localparam int DIGIT_W       = 6;
    localparam int CHAR_W        = 8;
    localparam int DIGIT_COUNT_W = 7;
    localparam int STEP_BITS     = 8;

    localparam logic [BASE_W-1:0] BASE_MIN = 6'd2;
    localparam logic [BASE_W-1:0] BASE_MAX = 6'd36;

    localparam logic [CHAR_W-1:0]  ASCII_ZERO     = 8'd48;
    localparam logic [CHAR_W-1:0]  ASCII_LOWER_A  = 8'd97;
    localparam logic [CHAR_W-1:0]  ASCII_UPPER_A  = 8'd65;
    localparam logic [DIGIT_W-1:0] DECIMAL_DIGITS = 6'd10;

    typedef struct packed {
        logic load;
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic               done;
        logic               quot_zero;
        logic [DIGIT_W-1:0] digit;
    } div_stat_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                     input logic upper);
        logic [CHAR_W-1:0] letter_base;
        letter_base = upper ? ASCII_UPPER_A : ASCII_LOWER_A;
        if (d < DECIMAL_DIGITS)
        begin
            return ASCII_ZERO + CHAR_W'(d);
        end
        return letter_base + CHAR_W'(d) - CHAR_W'(DECIMAL_DIGITS);
    endfunction

endpackage

// ----- hdl/rita_in_if.sv -----
// Request channel of the converter: valid/ready plus value, flags and base.
// Depends on rita_pkg for the field widths.
interface rita_in_if
    import rita_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [IN_VALUE_W-1:0] value;
    logic                  is_signed;
    logic                  upper_case;
    logic [BASE_W-1:0]     base;

    modport source (output valid, output value, output is_signed, output upper_case,
                    output base, input ready);
    modport sink   (input valid, input value, input is_signed, input upper_case,
                    input base, output ready);
endinterface

// ----- hdl/rita_out_if.sv -----
// Result channel of the converter: one ASCII character per transfer of this channel.
// Depends on rita_pkg for the field widths.
interface rita_out_if
    import rita_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [CHAR_W-1:0]        char_code;
    logic [DIGIT_COUNT_W-1:0] digit_count;
    logic                     last;

    modport source (output valid, output char_code, output digit_count, output last,
                    input ready);
    modport sink   (input valid, input char_code, input digit_count, input last,
                    output ready);
endinterface

// ----- hdl/radix_integer_to_ascii.sv -----
// Radix integer-to-ASCII converter, top level.
// The divider produces each digit in turn, working through the value 8 bits at a time;
// then each character is read from the digit store and presented until the sink takes it.
// One request at a time: a new request is taken only when idle, after its last character.
// Reset (rst_n, async, active low) clears control state; the digit store is not cleared.
module radix_integer_to_ascii
    import rita_pkg::*;
#(
    parameter int VALUE_WIDTH = 64,
    parameter int MAX_DIGITS  = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    rita_in_if.sink     in_chan,
    rita_out_if.source  out_chan
);

    localparam int NCHUNK = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
    localparam int QW     = NCHUNK * STEP_BITS;
    localparam int AW     = $clog2(MAX_DIGITS);
    localparam int CNT_W  = $clog2(MAX_DIGITS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_READ,
        ST_SEND
    } state_t;

    state_t               state_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     total_reg;
    logic [AW-1:0]        rd_idx_reg;
    logic                 upper_reg;
    logic [BASE_W-1:0]    base_reg;

    logic                   in_take;
    logic                   out_take;
    logic [VALUE_WIDTH-1:0] raw_value;
    logic [VALUE_WIDTH-1:0] magnitude;
    logic [BASE_W-1:0]      base_clamped;
    logic [CNT_W-1:0]       cnt_inc;
    logic                   more_digits;
    div_ctrl_t              div_ctrl;
    div_stat_t              div_stat;
    logic [DIGIT_W-1:0]     rd_digit;

    assign in_take  = in_chan.valid && in_chan.ready;
    assign out_take = out_chan.valid && out_chan.ready;

    assign raw_value = in_chan.value[VALUE_WIDTH-1:0];
    // most negative value wraps to itself, i.e. 2^(VALUE_WIDTH-1) as unsigned
    assign magnitude = (in_chan.is_signed && raw_value[VALUE_WIDTH-1])
                       ? (~raw_value + VALUE_WIDTH'(1))
                       : raw_value;

    always_comb
    begin
        if (in_chan.base < BASE_MIN)
        begin
            base_clamped = BASE_MIN;
        end
        else if (in_chan.base > BASE_MAX)
        begin
            base_clamped = BASE_MAX;
        end
        else
        begin
            base_clamped = in_chan.base;
        end
    end

    assign cnt_inc     = cnt_reg + CNT_W'(1);
    assign more_digits = !div_stat.quot_zero && (cnt_inc < CNT_W'(MAX_DIGITS));

    assign div_ctrl.load  = in_take;
    assign div_ctrl.start = in_take || (state_reg == ST_DIV && div_stat.done && more_digits);

    rita_divider #(
        .QW (QW)
    ) u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (div_ctrl),
        .load_value (QW'(magnitude)),
        .base       (in_take ? base_clamped : base_reg),
        .stat       (div_stat)
    );

    rita_digit_mem #(
        .DEPTH (MAX_DIGITS),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (state_reg == ST_DIV && div_stat.done),
        .waddr (cnt_reg[AW-1:0]),
        .wdata (div_stat.digit),
        .re    (state_reg == ST_READ),
        .raddr (rd_idx_reg),
        .rdata (rd_digit)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            total_reg  <= '0;
            rd_idx_reg <= '0;
            upper_reg  <= 1'b0;
            base_reg   <= BASE_MIN;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_take)
                    begin
                        upper_reg <= in_chan.upper_case;
                        base_reg  <= base_clamped;
                        cnt_reg   <= '0;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (div_stat.done)
                    begin
                        cnt_reg <= cnt_inc;
                        if (!more_digits)
                        begin
                            total_reg  <= cnt_inc;
                            rd_idx_reg <= cnt_reg[AW-1:0];
                            state_reg  <= ST_READ;
                        end
                    end
                end
                ST_READ:
                begin
                    state_reg <= ST_SEND;
                end
                ST_SEND:
                begin
                    if (out_take)
                    begin
                        if (rd_idx_reg == '0)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            rd_idx_reg <= rd_idx_reg - AW'(1);
                            state_reg  <= ST_READ;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign in_chan.ready        = (state_reg == ST_IDLE);
    assign out_chan.valid       = (state_reg == ST_SEND);
    assign out_chan.char_code   = digit_char(rd_digit, upper_reg);
    assign out_chan.digit_count = DIGIT_COUNT_W'(total_reg);
    assign out_chan.last        = (rd_idx_reg == '0);

endmodule

// ----- hdl/rita_digit_mem.sv -----
// Digit store: single write port, single read port, registered read data.
// Depends on rita_pkg for the digit width.
module rita_digit_mem
    import rita_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
)
(
    input  logic               clk,
    input  logic               we,
    input  logic [AW-1:0]      waddr,
    input  logic [DIGIT_W-1:0] wdata,
    input  logic               re,
    input  logic [AW-1:0]      raddr,
    output logic [DIGIT_W-1:0] rdata
);

    logic [DIGIT_W-1:0] mem [DEPTH];
    logic [DIGIT_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/rita_divider.sv -----
// Iterative divider: divides the working quotient by the base, 8 bits a cycle,
// leaving the new quotient in place and the remainder as the digit. Uses rita_pkg.
module rita_divider
    import rita_pkg::*;
#(
    parameter int QW = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  div_ctrl_t         ctrl,
    input  logic [QW-1:0]     load_value,
    input  logic [BASE_W-1:0] base,
    output div_stat_t         stat
);

    localparam int NCHUNK = QW / STEP_BITS;
    localparam int CW     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;

    logic [QW-1:0]        quot_reg;
    logic [DIGIT_W-1:0]   rem_reg;
    logic [CW-1:0]        chunk_reg;
    logic                 run_reg;
    logic                 done_reg;
    logic [STEP_BITS-1:0] top_bits;
    logic [STEP_BITS-1:0] qbits;
    logic [DIGIT_W:0]     rem_work;

    assign top_bits = quot_reg[QW-1 -: STEP_BITS];

    // restoring division, one quotient bit per step; remainder stays below base
    always_comb
    begin
        rem_work = {1'b0, rem_reg};
        qbits    = '0;
        for (int i = STEP_BITS - 1; i >= 0; i--)
        begin
            rem_work = {rem_work[DIGIT_W-1:0], top_bits[i]};
            if (rem_work >= {1'b0, base})
            begin
                rem_work = rem_work - {1'b0, base};
                qbits[i] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= 1'b0;
            done_reg  <= 1'b0;
            chunk_reg <= '0;
            quot_reg  <= '0;
            rem_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.start)
            begin
                if (ctrl.load)
                begin
                    quot_reg <= load_value;
                end
                rem_reg   <= '0;
                chunk_reg <= '0;
                run_reg   <= 1'b1;
            end
            else if (run_reg)
            begin
                quot_reg  <= (quot_reg << STEP_BITS) | QW'(qbits);
                rem_reg   <= rem_work[DIGIT_W-1:0];
                chunk_reg <= chunk_reg + CW'(1);
                if (chunk_reg == CW'(NCHUNK - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign stat.done      = done_reg;
    assign stat.quot_zero = (quot_reg == '0);
    assign stat.digit     = rem_reg;

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench of radix_integer_to_ascii: a directed table, then random requests.
// Depends on rita_pkg, rita_in_if and rita_out_if, and on the converter's top level.
module tb_top;
    import rita_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  RESET_CYCLES = 8;
    localparam int  RANDOM_REQS  = 360;
    localparam int  DRAIN_CYCLES = 200;
    localparam int  LIMIT_CYCLES = 3_000_000;
    localparam int  SRC_SIDE     = 0;
    localparam int  SINK_SIDE    = 1;

    typedef struct packed {
        logic [IN_VALUE_W-1:0] value;
        logic                  is_signed;
        logic                  upper_case;
        logic [BASE_W-1:0]     base;
    } conv_req_t;

    typedef struct packed {
        logic [CHAR_W-1:0]        char_code;
        logic [DIGIT_COUNT_W-1:0] digit_count;
        logic                     last;
    } ascii_char_t;

    logic clk = 1'b0;
    logic rst_n;

    rita_in_if  in_chan();
    rita_out_if out_chan();

    radix_integer_to_ascii DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_chan  (in_chan),
        .out_chan (out_chan)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    conv_req_t   directed_reqs[$];
    string       directed_text[$];
    ascii_char_t expected_chars[$];

    int unsigned cycle_count    = 0;
    int unsigned reqs_sent      = 0;
    int unsigned reqs_accepted  = 0;
    int unsigned chars_checked  = 0;
    int unsigned error_count    = 0;
    int unsigned longest_number = 0;
    int          calm_left[2]   = '{0, 0};

    // stretches with no idling, otherwise a random idle gap before each request or ready phase
    function automatic int draw_idle(input int side);
        if (calm_left[side] > 0)
        begin
            calm_left[side]--;
            return 0;
        end
        if ($urandom_range(0, 7) == 0)
        begin
            calm_left[side] = $urandom_range(8, 30);
            return 0;
        end
        return $urandom_range(0, 15);
    endfunction

    task automatic add_row(input logic [IN_VALUE_W-1:0] value, input logic sgn,
                           input logic upper, input logic [BASE_W-1:0] base,
                           input string text);
        conv_req_t r;
        r.value      = value;
        r.is_signed  = sgn;
        r.upper_case = upper;
        r.base       = base;
        directed_reqs.push_back(r);
        directed_text.push_back(text);
    endtask

    // digits by repeated division, least significant first, then emitted msd first
    task automatic predict_chars(input conv_req_t r);
        logic [IN_VALUE_W-1:0] quot;
        logic [BASE_W-1:0]     radix;
        logic [DIGIT_W-1:0]    digits [0:63];
        logic [DIGIT_W-1:0]    d;
        ascii_char_t           c;
        int                    n;
        radix = r.base;
        if (radix < BASE_MIN)
        begin
            radix = BASE_MIN;
        end
        if (radix > BASE_MAX)
        begin
            radix = BASE_MAX;
        end
        quot = (r.is_signed && r.value[IN_VALUE_W-1]) ? -r.value : r.value;
        n = 0;
        do
        begin
            digits[n] = DIGIT_W'(quot % radix);
            quot = quot / radix;
            n++;
        end
        while (quot != 0 && n < 64);
        for (int k = 0; k < n; k++)
        begin
            d = digits[n-1-k];
            if (d < DECIMAL_DIGITS)
            begin
                c.char_code = ASCII_ZERO + CHAR_W'(d);
            end
            else
            begin
                c.char_code = (r.upper_case ? ASCII_UPPER_A : ASCII_LOWER_A)
                              + CHAR_W'(d) - CHAR_W'(DECIMAL_DIGITS);
            end
            c.digit_count = DIGIT_COUNT_W'(n);
            c.last        = (k == n - 1);
            expected_chars.push_back(c);
        end
        if (n > longest_number)
        begin
            longest_number = n;
        end
    endtask

    task automatic push_typed(input string text);
        ascii_char_t c;
        for (int k = 0; k < text.len(); k++)
        begin
            c.char_code   = text[k];
            c.digit_count = DIGIT_COUNT_W'(text.len());
            c.last        = (k == text.len() - 1);
            expected_chars.push_back(c);
        end
        if (text.len() > longest_number)
        begin
            longest_number = text.len();
        end
    endtask

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        error_count++;
        $display("MISMATCH at cycle %0d, character %0d: %s got %0h, expected %0h",
                 cycle_count, chars_checked, field, got, want);
    endtask

    task automatic send_request(input conv_req_t r);
        int gap;
        gap = draw_idle(SRC_SIDE);
        if (gap > 0)
        begin
            in_chan.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_chan.valid      <= 1'b1;
        in_chan.value      <= r.value;
        in_chan.is_signed  <= r.is_signed;
        in_chan.upper_case <= r.upper_case;
        in_chan.base       <= r.base;
        reqs_sent++;
        @(posedge clk);
        while (!in_chan.ready)
        begin
            @(posedge clk);
        end
    endtask

    function automatic conv_req_t random_request();
        conv_req_t             r;
        logic [IN_VALUE_W-1:0] raw;
        logic [IN_VALUE_W-1:0] near;
        int                    kind;
        raw  = {$urandom, $urandom};
        near = IN_VALUE_W'($urandom_range(0, 40));
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1: r.value = raw;
            2:    r.value = near;
            // around the most negative value and around minus one
            3:    r.value = raw[0] ? ({1'b1, {(IN_VALUE_W-1){1'b0}}} + near) : (-near);
            default: r.value = raw >> $urandom_range(1, 63);
        endcase
        r.is_signed  = 1'($urandom_range(0, 1));
        r.upper_case = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 7) == 0)
        begin
            r.base = BASE_W'($urandom_range(0, 63));
        end
        else
        begin
            r.base = BASE_W'($urandom_range(2, 36));
        end
        return r;
    endfunction

    // expect characters (typed or predicted) on every accepted request, check every accepted character
    always @(posedge clk)
    begin
        ascii_char_t want;
        conv_req_t   r;
        cycle_count++;
        if (in_chan.valid && in_chan.ready)
        begin
            r.value      = in_chan.value;
            r.is_signed  = in_chan.is_signed;
            r.upper_case = in_chan.upper_case;
            r.base       = in_chan.base;
            if (reqs_accepted < directed_text.size() && directed_text[reqs_accepted] != "")
            begin
                push_typed(directed_text[reqs_accepted]);
            end
            else
            begin
                predict_chars(r);
            end
            reqs_accepted++;
        end
        if (out_chan.valid && out_chan.ready)
        begin
            if (expected_chars.size() == 0)
            begin
                report_mismatch("unexpected char_code", 64'(out_chan.char_code), 64'(0));
            end
            else
            begin
                want = expected_chars.pop_front();
                if (out_chan.char_code !== want.char_code)
                begin
                    report_mismatch("char_code", 64'(out_chan.char_code),
                                    64'(want.char_code));
                end
                if (out_chan.digit_count !== want.digit_count)
                begin
                    report_mismatch("digit_count", 64'(out_chan.digit_count),
                                    64'(want.digit_count));
                end
                if (out_chan.last !== want.last)
                begin
                    report_mismatch("last", 64'(out_chan.last), 64'(want.last));
                end
            end
            chars_checked++;
        end
    end

    initial
    begin
        int stall;
        out_chan.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
        begin
            @(posedge clk);
        end
        forever
        begin
            stall = draw_idle(SINK_SIDE);
            if (stall > 0)
            begin
                out_chan.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_chan.ready <= 1'b1;
            @(posedge clk);
            while (!out_chan.valid)
            begin
                @(posedge clk);
            end
        end
    end

    initial
    begin
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
        end
        $display("timeout after %0d cycles, %0d characters still expected",
                 cycle_count, expected_chars.size());
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        in_chan.valid      <= 1'b0;
        in_chan.value      <= '0;
        in_chan.is_signed  <= 1'b0;
        in_chan.upper_case <= 1'b0;
        in_chan.base       <= '0;
        rst_n              <= 1'b0;

        // value, signed, upper, base, typed result ("" = predicted)
        add_row(64'd0,                  1'b0, 1'b0, 6'd10, "0");
        add_row(64'd0,                  1'b1, 1'b1, 6'd2,  "0");
        add_row(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 6'd16, "ffffffffffffffff");
        add_row(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1, 6'd16, "FFFFFFFFFFFFFFFF");
        add_row(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 6'd2,  "");
        add_row(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 6'd10, "1");
        add_row(64'hFFFF_FFFF_FFFF_FFFE, 1'b1, 1'b0, 6'd3,  "2");
        add_row(64'h8000_0000_0000_0000, 1'b1, 1'b0, 6'd16, "8000000000000000");
        add_row(64'h8000_0000_0000_0000, 1'b1, 1'b1, 6'd2,  "");
        add_row(64'h8000_0000_0000_0000, 1'b0, 1'b0, 6'd10, "9223372036854775808");
        add_row(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 6'd10, "18446744073709551615");
        add_row(64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 6'd36, "");
        add_row(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1, 6'd36, "");
        add_row(64'd5,                  1'b0, 1'b0, 6'd0,  "101");
        add_row(64'd5,                  1'b1, 1'b0, 6'd1,  "101");
        add_row(64'd35,                 1'b0, 1'b0, 6'd63, "z");
        add_row(64'd35,                 1'b0, 1'b1, 6'd37, "Z");
        add_row(64'd35,                 1'b0, 1'b1, 6'd36, "Z");
        add_row(64'd10,                 1'b0, 1'b0, 6'd36, "a");
        add_row(64'd9,                  1'b0, 1'b0, 6'd10, "9");
        add_row(64'd12345,              1'b0, 1'b0, 6'd10, "12345");
        add_row(64'd255,                1'b0, 1'b0, 6'd8,  "377");
        add_row(64'h0123_4567_89AB_CDEF, 1'b0, 1'b1, 6'd16, "123456789ABCDEF");
        add_row(64'hDEAD_BEEF_0BAD_F00D, 1'b1, 1'b1, 6'd7,  "");

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_reqs[i])
        begin
            send_request(directed_reqs[i]);
        end
        for (int i = 0; i < RANDOM_REQS; i++)
        begin
            send_request(random_request());
        end
        in_chan.valid <= 1'b0;

        while (expected_chars.size() != 0 || reqs_accepted != reqs_sent)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d requests (%0d from the directed table), %0d characters checked",
                 reqs_accepted, directed_reqs.size(), chars_checked);
        $display("longest number %0d digits, %0d mismatches, %0d cycles",
                 longest_number, error_count, cycle_count);
        if (error_count == 0 && expected_chars.size() == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
